// ===== sv/segment_triangle_intersection_top_macros.svh =====
`ifndef SEGMENT_TRIANGLE_INTERSECTION_TOP_MACROS_SVH
`define SEGMENT_TRIANGLE_INTERSECTION_TOP_MACROS_SVH

// same-cycle check on i_clk, off during reset
`define STI_CHECK(name, ante, cons, text) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(text);

// next-cycle check on i_clk, off during reset
`define STI_CHECK_NEXT(name, ante, cons, text) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(text);

`endif

// ===== sv/sti_pkg.sv =====
package sti_pkg;

    localparam int COORD_BITS = 16;
    localparam int PT_W       = 3 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int CROSS_W    = 2 * DIFF_W + 1;
    localparam int PROD_W     = DIFF_W + CROSS_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int MAG_W      = DOT_W - 1;
    localparam int REM_W      = MAG_W + 1;
    localparam int DIV_STEPS  = COORD_BITS;
    localparam int THR_W      = 32;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [COORD_BITS-1:0] t_ucoord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [CROSS_W-1:0]    t_cross;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [DOT_W-1:0]      t_dot;
    typedef logic        [MAG_W-1:0]      t_mag;

    typedef struct packed {
        logic [PT_W-1:0] seg_start;
        logic [PT_W-1:0] seg_end;
        logic [PT_W-1:0] corner_a;
        logic [PT_W-1:0] corner_b;
        logic [PT_W-1:0] corner_c;
    } t_in;

    typedef struct packed {
        logic   hit;
        t_coord hit_x;
        t_coord hit_y;
        t_coord hit_z;
    } t_out;

    // differences
    typedef struct packed {
        t_coord [2:0] st;
        t_diff  [2:0] d;
        t_diff  [2:0] eb;
        t_diff  [2:0] ec;
        t_diff  [2:0] r;
    } t_s1;

    // cross products
    typedef struct packed {
        t_coord [2:0] st;
        t_diff  [2:0] d;
        t_diff  [2:0] eb;
        t_diff  [2:0] ec;
        t_diff  [2:0] r;
        t_cross [2:0] p;
        t_cross [2:0] g;
    } t_s2;

    // dot product terms
    typedef struct packed {
        t_coord [2:0] st;
        t_diff  [2:0] d;
        t_prod  [2:0] det_t;
        t_prod  [2:0] nu_t;
        t_prod  [2:0] nv_t;
        t_prod  [2:0] nt_t;
    } t_s3;

    typedef struct packed {
        t_coord [2:0] st;
        t_diff  [2:0] d;
        t_dot         det;
        t_dot         nu;
        t_dot         nv;
        t_dot         nt;
    } t_s4;

    // sign normalized so that det is not negative
    typedef struct packed {
        t_coord [2:0] st;
        t_diff  [2:0] d;
        logic         det_zero;
        t_dot         mag;
        t_dot         nu;
        t_dot         nv;
        t_dot         nt;
    } t_s5;

    // quotient pipeline state
    typedef struct packed {
        logic          hit;
        t_mag          mag;
        t_mag          nt;
        t_coord  [2:0] st;
        t_ucoord [2:0] dabs;
        logic    [2:0] dneg;
        t_mag    [2:0] rem;
        t_ucoord [2:0] quo;
    } t_dv;

endpackage

// ===== sv/sti_geom.sv =====
module sti_geom (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  sti_pkg::t_in  i_data,
    output logic          o_valid,
    output sti_pkg::t_s2  o_data
);

    sti_pkg::t_s1 r_s1, n_s1;
    sti_pkg::t_s2 r_s2, n_s2;
    logic         r_v1, r_v2;

    function automatic sti_pkg::t_coord get_coord(
        input logic [sti_pkg::PT_W-1:0] pt,
        input int                       axis
    );
        return sti_pkg::t_coord'(pt[axis*sti_pkg::COORD_BITS +: sti_pkg::COORD_BITS]);
    endfunction

    function automatic sti_pkg::t_diff sub_coord(
        input sti_pkg::t_coord a,
        input sti_pkg::t_coord b
    );
        return sti_pkg::t_diff'(a) - sti_pkg::t_diff'(b);
    endfunction

    function automatic sti_pkg::t_cross xmul(
        input sti_pkg::t_diff a,
        input sti_pkg::t_diff b,
        input sti_pkg::t_diff c,
        input sti_pkg::t_diff e
    );
        return (sti_pkg::t_cross'(a) * sti_pkg::t_cross'(b))
             - (sti_pkg::t_cross'(c) * sti_pkg::t_cross'(e));
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s1.st[k] = get_coord(i_data.seg_start, k);
            n_s1.d[k]  = sub_coord(get_coord(i_data.seg_end, k),
                                   get_coord(i_data.seg_start, k));
            n_s1.eb[k] = sub_coord(get_coord(i_data.corner_b, k),
                                   get_coord(i_data.corner_a, k));
            n_s1.ec[k] = sub_coord(get_coord(i_data.corner_c, k),
                                   get_coord(i_data.corner_a, k));
            n_s1.r[k]  = sub_coord(get_coord(i_data.seg_start, k),
                                   get_coord(i_data.corner_a, k));
        end
    end

    always_comb begin
        n_s2.st   = r_s1.st;
        n_s2.d    = r_s1.d;
        n_s2.eb   = r_s1.eb;
        n_s2.ec   = r_s1.ec;
        n_s2.r    = r_s1.r;
        // p = d x ec, g = r x eb
        n_s2.p[0] = xmul(r_s1.d[1], r_s1.ec[2], r_s1.d[2], r_s1.ec[1]);
        n_s2.p[1] = xmul(r_s1.d[2], r_s1.ec[0], r_s1.d[0], r_s1.ec[2]);
        n_s2.p[2] = xmul(r_s1.d[0], r_s1.ec[1], r_s1.d[1], r_s1.ec[0]);
        n_s2.g[0] = xmul(r_s1.r[1], r_s1.eb[2], r_s1.r[2], r_s1.eb[1]);
        n_s2.g[1] = xmul(r_s1.r[2], r_s1.eb[0], r_s1.r[0], r_s1.eb[2]);
        n_s2.g[2] = xmul(r_s1.r[0], r_s1.eb[1], r_s1.r[1], r_s1.eb[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_s2;

endmodule

// ===== sv/sti_dot.sv =====
module sti_dot (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [sti_pkg::THR_W-1:0]   i_thr,
    input  logic                        i_valid,
    input  sti_pkg::t_s2                i_data,
    output logic                        o_valid,
    output sti_pkg::t_dv                o_data
);

    sti_pkg::t_s3 r_s3, n_s3;
    sti_pkg::t_s4 r_s4, n_s4;
    sti_pkg::t_s5 r_s5, n_s5;
    sti_pkg::t_dv r_s6, n_s6;
    logic         r_v3, r_v4, r_v5, r_v6;

    logic                        w_neg;
    logic [sti_pkg::DOT_W-1:0]   w_mag_u;
    logic [sti_pkg::DOT_W-1:0]   w_thr_ext;
    sti_pkg::t_dot               w_uv;
    logic                        w_inside;

    function automatic sti_pkg::t_prod pmul(
        input sti_pkg::t_diff  a,
        input sti_pkg::t_cross b
    );
        return sti_pkg::t_prod'(a) * sti_pkg::t_prod'(b);
    endfunction

    function automatic sti_pkg::t_dot sum3(input sti_pkg::t_prod [2:0] t);
        return sti_pkg::t_dot'(t[0]) + sti_pkg::t_dot'(t[1]) + sti_pkg::t_dot'(t[2]);
    endfunction

    function automatic sti_pkg::t_ucoord abs_diff(input sti_pkg::t_diff d);
        logic [sti_pkg::DIFF_W-1:0] m;
        m = d[sti_pkg::DIFF_W-1] ? sti_pkg::DIFF_W'(-d) : d;
        return m[sti_pkg::COORD_BITS-1:0];
    endfunction

    always_comb begin
        n_s3.st = i_data.st;
        n_s3.d  = i_data.d;
        for (int k = 0; k < 3; k++) begin
            n_s3.det_t[k] = pmul(i_data.eb[k], i_data.p[k]);
            n_s3.nu_t[k]  = pmul(i_data.r[k],  i_data.p[k]);
            n_s3.nv_t[k]  = pmul(i_data.d[k],  i_data.g[k]);
            n_s3.nt_t[k]  = pmul(i_data.ec[k], i_data.g[k]);
        end
    end

    always_comb begin
        n_s4.st  = r_s3.st;
        n_s4.d   = r_s3.d;
        n_s4.det = sum3(r_s3.det_t);
        n_s4.nu  = sum3(r_s3.nu_t);
        n_s4.nv  = sum3(r_s3.nv_t);
        n_s4.nt  = sum3(r_s3.nt_t);
    end

    assign w_neg = r_s4.det[sti_pkg::DOT_W-1];

    always_comb begin
        n_s5.st       = r_s4.st;
        n_s5.d        = r_s4.d;
        n_s5.det_zero = (r_s4.det == '0);
        n_s5.mag      = w_neg ? -r_s4.det : r_s4.det;
        n_s5.nu       = w_neg ? -r_s4.nu  : r_s4.nu;
        n_s5.nv       = w_neg ? -r_s4.nv  : r_s4.nv;
        n_s5.nt       = w_neg ? -r_s4.nt  : r_s4.nt;
    end

    // range tests on u, v, u+v and t, plus the nonzero and threshold tests on det
    assign w_mag_u   = r_s5.mag;
    assign w_thr_ext = sti_pkg::DOT_W'(i_thr);
    assign w_uv      = r_s5.nu + r_s5.nv;
    assign w_inside  = !r_s5.det_zero
                    && (w_mag_u >= w_thr_ext)
                    && ($signed(r_s5.nu) >= 0) && ($signed(r_s5.nu) <= $signed(r_s5.mag))
                    && ($signed(r_s5.nv) >= 0) && ($signed(w_uv) <= $signed(r_s5.mag))
                    && ($signed(r_s5.nt) >= 0) && ($signed(r_s5.nt) <= $signed(r_s5.mag));

    always_comb begin
        n_s6.hit = w_inside;
        n_s6.mag = r_s5.mag[sti_pkg::MAG_W-1:0];
        n_s6.nt  = r_s5.nt[sti_pkg::MAG_W-1:0];
        n_s6.st  = r_s5.st;
        for (int k = 0; k < 3; k++) begin
            n_s6.dabs[k] = abs_diff(r_s5.d[k]);
            n_s6.dneg[k] = r_s5.d[k][sti_pkg::DIFF_W-1];
            n_s6.rem[k]  = '0;
            n_s6.quo[k]  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
        end
    end

    assign o_valid = r_v6;
    assign o_data  = r_s6;

endmodule

// ===== sv/sti_div.sv =====
module sti_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  sti_pkg::t_dv  i_data,
    output logic          o_valid,
    output sti_pkg::t_dv  o_data
);

    sti_pkg::t_dv                      r_st [sti_pkg::DIV_STEPS];
    sti_pkg::t_dv                      n_st [sti_pkg::DIV_STEPS];
    logic [sti_pkg::DIV_STEPS-1:0]     r_vld;

    // one quotient bit of |d| * nt / mag per lane; nt <= mag so digit is 0..2
    function automatic sti_pkg::t_dv div_step(input sti_pkg::t_dv x);
        sti_pkg::t_dv                y;
        logic [sti_pkg::REM_W-1:0]   r2;
        logic [sti_pkg::REM_W-1:0]   m1;
        logic [sti_pkg::REM_W-1:0]   m2;
        logic [sti_pkg::REM_W-1:0]   add;
        logic                        ge1;
        logic                        ge2;
        y  = x;
        m1 = sti_pkg::REM_W'(x.mag);
        m2 = {m1[sti_pkg::REM_W-2:0], 1'b0};
        for (int k = 0; k < 3; k++) begin
            add = x.dabs[k][sti_pkg::COORD_BITS-1] ? sti_pkg::REM_W'(x.nt) : '0;
            r2  = {x.rem[k], 1'b0} + add;
            ge2 = (r2 >= m2);
            ge1 = (r2 >= m1);
            if (ge2) begin
                r2 = r2 - m2;
            end else if (ge1) begin
                r2 = r2 - m1;
            end
            y.rem[k]  = r2[sti_pkg::MAG_W-1:0];
            y.quo[k]  = {x.quo[k][sti_pkg::COORD_BITS-2:0], 1'b0}
                      + sti_pkg::COORD_BITS'({ge2, ge1 & !ge2});
            y.dabs[k] = {x.dabs[k][sti_pkg::COORD_BITS-2:0], 1'b0};
        end
        return y;
    endfunction

    always_comb begin
        n_st[0] = div_step(i_data);
        for (int i = 1; i < sti_pkg::DIV_STEPS; i++) begin
            n_st[i] = div_step(r_st[i-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[sti_pkg::DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < sti_pkg::DIV_STEPS; i++) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    assign o_valid = r_vld[sti_pkg::DIV_STEPS-1];
    assign o_data  = r_st[sti_pkg::DIV_STEPS-1];

endmodule

// ===== sv/segment_triangle_intersection_top.sv =====
// Segment / triangle intersection: one segment-triangle pair per cycle when not stalled, through
// 2 difference/cross stages, 4 dot-product and test stages, 16 quotient stages that give
// one bit of the hit point's offset each, and 1 output register. The whole pipeline
// advances together; it stops only while a result sits in the output register and is not
// taken, so a held result also holds o_in_ready low. The parallel threshold is compared
// against the raw determinant magnitude and should be written only while the block is idle.
`include "segment_triangle_intersection_top_macros.svh"

module segment_triangle_intersection_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sti_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sti_pkg::t_out               o_out,
    input  logic                        i_cfg_we,
    input  logic [sti_pkg::THR_W-1:0]   i_cfg_data
);

    logic [sti_pkg::THR_W-1:0] r_thr;
    logic                      w_en;
    logic                      w_s2_vld;
    sti_pkg::t_s2              w_s2;
    logic                      w_s6_vld;
    sti_pkg::t_dv              w_s6;
    logic                      w_dv_vld;
    sti_pkg::t_dv              w_dv;
    sti_pkg::t_out             r_out, n_out;
    logic                      r_out_vld;

    function automatic sti_pkg::t_coord hit_coord(
        input logic             hit,
        input sti_pkg::t_coord  st,
        input sti_pkg::t_ucoord quo,
        input logic             neg
    );
        sti_pkg::t_ucoord q;
        q = neg ? -quo : quo;
        return hit ? sti_pkg::t_coord'(st + q) : '0;
    endfunction

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= sti_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    sti_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in),
        .o_valid (w_s2_vld),
        .o_data  (w_s2)
    );

    sti_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_thr   (r_thr),
        .i_valid (w_s2_vld),
        .i_data  (w_s2),
        .o_valid (w_s6_vld),
        .o_data  (w_s6)
    );

    sti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s6_vld),
        .i_data  (w_s6),
        .o_valid (w_dv_vld),
        .o_data  (w_dv)
    );

    always_comb begin
        n_out.hit   = w_dv.hit;
        n_out.hit_x = hit_coord(w_dv.hit, w_dv.st[0], w_dv.quo[0], w_dv.dneg[0]);
        n_out.hit_y = hit_coord(w_dv.hit, w_dv.st[1], w_dv.quo[1], w_dv.dneg[1]);
        n_out.hit_z = hit_coord(w_dv.hit, w_dv.st[2], w_dv.quo[2], w_dv.dneg[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `STI_CHECK(a_miss_zero, o_out_valid && !o_out.hit, o_out.hit_x == '0 && o_out.hit_y == '0 && o_out.hit_z == '0, "miss carries a nonzero point")
    `STI_CHECK(a_out_from_pipe, $rose(o_out_valid), $past(w_dv_vld), "result without a pipeline item")
    `STI_CHECK_NEXT(a_stall_freeze, !o_in_ready, $stable(w_dv_vld) && $stable(w_dv), "pipeline moved during a stall")
    `STI_CHECK_NEXT(a_cfg_write, i_cfg_we, r_thr == $past(i_cfg_data), "threshold write lost")

endmodule
